// ===== design/b64c_pkg.sv =====
// shared types, character constants and alphabet functions of the base64 codec
package b64c_pkg;

   localparam int          QUEUE_DEPTH_DEF = 2;
   localparam int          CSR_ADDR_W      = 3;
   localparam logic        REG_DIRECTION   = 1'b0;
   localparam logic        DIR_ENCODE      = 1'b0;
   localparam logic        DIR_DECODE      = 1'b1;

   localparam logic [7:0]  CHR_UPPER_A = 8'h41;
   localparam logic [7:0]  CHR_UPPER_Z = 8'h5a;
   localparam logic [7:0]  CHR_LOWER_A = 8'h61;
   localparam logic [7:0]  CHR_LOWER_Z = 8'h7a;
   localparam logic [7:0]  CHR_DIGIT_0 = 8'h30;
   localparam logic [7:0]  CHR_DIGIT_9 = 8'h39;
   localparam logic [7:0]  CHR_PLUS    = 8'h2b;
   localparam logic [7:0]  CHR_SLASH   = 8'h2f;
   localparam logic [7:0]  CHR_PAD     = 8'h3d;
   localparam logic [6:0]  NO_VALUE    = 7'd64;

   // up to four results produced by one item
   typedef struct packed {
      logic [1:0]      final_idx;
      logic [3:0][7:0] data;
      logic [3:0]      last;
      logic [3:0]      bad;
   } job_type;

   function automatic logic [7:0] sym_of(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (v < 6'd26) return CHR_UPPER_A + w;
      if (v < 6'd52) return CHR_LOWER_A + w - 8'd26;
      if (v < 6'd62) return CHR_DIGIT_0 + w - 8'd52;
      if (v == 6'd62) return CHR_PLUS;
      return CHR_SLASH;
   endfunction

   function automatic logic [6:0] val_of(input logic [7:0] c);
      if (c inside {[CHR_UPPER_A:CHR_UPPER_Z]}) return 7'(c - CHR_UPPER_A);
      if (c inside {[CHR_LOWER_A:CHR_LOWER_Z]}) return 7'(c - CHR_LOWER_A + 8'd26);
      if (c inside {[CHR_DIGIT_0:CHR_DIGIT_9]}) return 7'(c - CHR_DIGIT_0 + 8'd52);
      if (c == CHR_PLUS) return 7'd62;
      if (c == CHR_SLASH) return 7'd63;
      return NO_VALUE;
   endfunction

endpackage

// ===== design/b64c_if.sv =====
// valid/ready channel interfaces for input items and result items
interface b64c_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_in;
   logic       in_last;
   modport source (output valid, output data_in, output in_last, input ready);
   modport sink   (input valid, input data_in, input in_last, output ready);
endinterface

interface b64c_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;
   logic       out_last;
   logic       bad_symbol;
   modport source (output valid, output data_out, output out_last, output bad_symbol,
                   input ready);
   modport sink   (input valid, input data_out, input out_last, input bad_symbol,
                   output ready);
endinterface

// ===== design/b64c_front.sv =====
// front end: accepts items, keeps group state and builds the results of each item
module b64c_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              direction,
   input  logic              cfg_clear,
   input  logic              queue_full,
   b64c_req_if.sink          req,
   output logic              push,
   output b64c_pkg::job_type job
);
   import b64c_pkg::*;

   logic [1:0] pos_ff, pos_in;
   logic [5:0] held_ff, held_in;
   logic       pad_ff, pad_in;
   logic       err_ff, err_in;
   logic [7:0] pend_ff, pend_in;
   logic       pend_v_ff, pend_v_in;

   logic       accept;
   logic [2:0] n;
   logic [7:0] b;
   logic [6:0] v;
   logic [7:0] byte_v;
   logic       do_push;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign b         = req.data_in;

   always_comb begin
      pos_in    = pos_ff;
      held_in   = held_ff;
      pad_in    = pad_ff;
      err_in    = err_ff;
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      job       = '0;
      n         = 3'd0;
      v         = val_of(b);
      byte_v    = 8'h00;
      do_push   = 1'b0;
      if (accept) begin
         if (direction == DIR_ENCODE) begin
            case (pos_ff)
               2'd0: begin
                  job.data[0] = sym_of(b[7:2]);
                  held_in     = {b[1:0], 4'b0000};
                  pos_in      = 2'd1;
                  n           = 3'd1;
                  if (req.in_last) begin
                     job.data[1] = sym_of(held_in);
                     job.data[2] = CHR_PAD;
                     job.data[3] = CHR_PAD;
                     job.last[3] = 1'b1;
                     n           = 3'd4;
                  end
               end
               2'd1: begin
                  job.data[0] = sym_of(held_ff | {2'b00, b[7:4]});
                  held_in     = {b[3:0], 2'b00};
                  pos_in      = 2'd2;
                  n           = 3'd1;
                  if (req.in_last) begin
                     job.data[1] = sym_of(held_in);
                     job.data[2] = CHR_PAD;
                     job.last[2] = 1'b1;
                     n           = 3'd3;
                  end
               end
               default: begin
                  job.data[0] = sym_of(held_ff | {4'b0000, b[7:6]});
                  job.data[1] = sym_of(b[5:0]);
                  job.last[1] = req.in_last;
                  held_in     = 6'd0;
                  pos_in      = 2'd0;
                  n           = 3'd2;
               end
            endcase
         end else begin
            if (!pad_ff) begin
               if (b == CHR_PAD) begin
                  if (pos_ff < 2'd2) err_in = 1'b1;
                  pad_in = 1'b1;
               end else if (v == NO_VALUE) begin
                  err_in = 1'b1;
               end else begin
                  case (pos_ff)
                     2'd0: begin
                        held_in = v[5:0];
                        pos_in  = 2'd1;
                     end
                     2'd1: begin
                        byte_v  = {held_ff, v[5:4]};
                        do_push = 1'b1;
                        held_in = {2'b00, v[3:0]};
                        pos_in  = 2'd2;
                     end
                     2'd2: begin
                        byte_v  = {held_ff[3:0], v[5:2]};
                        do_push = 1'b1;
                        held_in = {4'b0000, v[1:0]};
                        pos_in  = 2'd3;
                     end
                     default: begin
                        byte_v  = {held_ff[1:0], v[5:0]};
                        do_push = 1'b1;
                        held_in = 6'd0;
                        pos_in  = 2'd0;
                     end
                  endcase
               end
            end
            // each decoded byte waits one place so the final one can carry out_last
            if (do_push) begin
               if (pend_v_ff) begin
                  job.data[0] = pend_ff;
                  job.bad[0]  = err_ff;
                  n           = 3'd1;
               end
               pend_in   = byte_v;
               pend_v_in = 1'b1;
            end
            if (req.in_last) begin
               if (!pad_in && pos_in != 2'd0) err_in = 1'b1;
               if (pend_v_in) begin
                  job.data[n[1:0]] = pend_in;
                  job.bad[n[1:0]]  = err_in;
               end else begin
                  job.data[n[1:0]] = 8'h00;
                  job.bad[n[1:0]]  = 1'b1;
               end
               job.last[n[1:0]] = 1'b1;
               n = n + 3'd1;
            end
         end
         if (req.in_last) begin
            pos_in    = 2'd0;
            held_in   = 6'd0;
            pad_in    = 1'b0;
            err_in    = 1'b0;
            pend_in   = 8'h00;
            pend_v_in = 1'b0;
         end
      end
      if (cfg_clear) begin
         pos_in    = 2'd0;
         held_in   = 6'd0;
         pad_in    = 1'b0;
         err_in    = 1'b0;
         pend_in   = 8'h00;
         pend_v_in = 1'b0;
      end
      job.final_idx = 2'(n - 3'd1);
      push          = accept && (n != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 2'd0;
         held_ff   <= 6'd0;
         pad_ff    <= 1'b0;
         err_ff    <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         held_ff   <= held_in;
         pad_ff    <= pad_in;
         err_ff    <= err_in;
         pend_v_ff <= pend_v_in;
      end
      pend_ff <= pend_in;
   end

endmodule

// ===== design/b64c_queue.sv =====
// short fifo of result groups between front and back end
module b64c_queue #(
   parameter int DEPTH = b64c_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64c_pkg::job_type push_job,
   input  logic              pop,
   output logic              not_empty,
   output logic              full,
   output b64c_pkg::job_type head
);
   import b64c_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      if (do_pop)  rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      if (do_push && !do_pop) cnt_in = cnt_ff + CNT_W'(1);
      if (do_pop && !do_push) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wr_ff] <= push_job;
   end

endmodule

// ===== design/b64c_back.sv =====
// back end: walks the results of the head group into the output register
module b64c_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  b64c_pkg::job_type job,
   output logic              pop,
   b64c_rsp_if.source        rsp
);
   import b64c_pkg::*;

   logic       out_v_ff, out_v_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       bad_ff, bad_in;
   logic [1:0] idx_ff, idx_in;
   logic       load;

   assign load = job_valid && (!out_v_ff || rsp.ready);
   assign pop  = load && (idx_ff == job.final_idx);

   always_comb begin
      out_v_in = out_v_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      bad_in   = bad_ff;
      idx_in   = idx_ff;
      if (load) begin
         out_v_in = 1'b1;
         data_in  = job.data[idx_ff];
         last_in  = job.last[idx_ff];
         bad_in   = job.bad[idx_ff];
         idx_in   = pop ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp.ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         out_v_ff <= out_v_in;
         idx_ff   <= idx_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
      bad_ff  <= bad_in;
   end

   assign rsp.valid      = out_v_ff;
   assign rsp.data_out   = data_ff;
   assign rsp.out_last   = last_ff;
   assign rsp.bad_symbol = bad_ff;

endmodule

// ===== design/base64_codec.sv =====
// top level of the base64 encoder/decoder with its direction register
//
//   port     role        carries
//   req_ch   item in     data_in[7:0], in_last
//   rsp_ch   item out    data_out[7:0], out_last, bad_symbol
//   p*       apb slave   direction at byte address 0
//
// an item is taken every cycle while the group queue has room; each item
// yields zero to four results, sent one per cycle from the output register
// while rsp_ch is ready; encoding, with four characters for every three
// bytes, is bound by the output port. synchronous reset; no clearing pass.
// a stalled rsp_ch fills the queue, after which req_ch.ready drops.
module base64_codec #(
   parameter int QUEUE_DEPTH = b64c_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   b64c_req_if.sink                        req_ch,
   b64c_rsp_if.source                      rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [b64c_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import b64c_pkg::*;

   logic    dir_ff, dir_in;
   logic    cfg_clear;
   logic    push, pop, q_full, q_not_empty;
   job_type push_job, head_job;

   assign pready    = 1'b1;
   assign cfg_clear = psel && penable && pwrite && (paddr[2] == REG_DIRECTION);
   assign dir_in    = cfg_clear ? pwdata[0] : dir_ff;
   assign prdata    = (paddr[2] == REG_DIRECTION) ? {31'd0, dir_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) dir_ff <= DIR_ENCODE;
      else       dir_ff <= dir_in;
   end

   b64c_front u_front (
      .clock      (clock),
      .reset      (reset),
      .direction  (dir_ff),
      .cfg_clear  (cfg_clear),
      .queue_full (q_full),
      .req        (req_ch),
      .push       (push),
      .job        (push_job)
   );

   b64c_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .not_empty (q_not_empty),
      .full      (q_full),
      .head      (head_job)
   );

   b64c_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_not_empty),
      .job       (head_job),
      .pop       (pop),
      .rsp       (rsp_ch)
   );

endmodule
